FILE: sv/fpba_pkg.sv
// ---------------------------------------------------------------------------
// fpba_pkg: shared types and constants for the fit policy block allocator
// Field widths, register indexes, operation codes and the control structs
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int ENTRY_W    = 4;
  localparam int AMOUNT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Defaults for the top-level parameters.
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

  // Operation codes of an input word.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_policy_t;

  typedef struct packed {
    logic load;     // write a loaded size and prepare its result
    logic capture;  // latch a request and set up the scan
    logic scan;     // step the table scan
    logic commit;   // update the chosen entry and prepare the result
    logic push;     // move the prepared result into the output register
  } fpba_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } fpba_status_t;

endpackage : fpba_pkg

`default_nettype wire

FILE: sv/fpba_if.sv
// ---------------------------------------------------------------------------
// fpba_if: valid/ready channels of the fit policy block allocator
// One interface for the input words and one for the result words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpba_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [fpba_pkg::ENTRY_W-1:0]  entry_index;
  logic [fpba_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, output operation, output entry_index, output amount,
                  input ready);
  modport sink   (input valid, input operation, input entry_index, input amount,
                  output ready);
endinterface : fpba_in_if

interface fpba_out_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [fpba_pkg::ENTRY_W-1:0]  chosen_block;
  logic [fpba_pkg::AMOUNT_W-1:0] space_left;

  modport source (output valid, output granted, output chosen_block, output space_left,
                  input ready);
  modport sink   (input valid, input granted, input chosen_block, input space_left,
                  output ready);
endinterface : fpba_out_if

`default_nettype wire

FILE: sv/fit_policy_block_allocator.sv
// ---------------------------------------------------------------------------
// fit_policy_block_allocator: first, best, worst and next fit block allocator
// Keeps the free size of each memory block and places requests by policy.
//
// Usage: words enter on in_ch and results leave on out_ch, both valid/ready;
// a word moves at a clock edge where valid and ready are both high. Each
// input word gives exactly one result word. A load word writes one table
// entry and resets the next-fit pointer; a request word is placed under the
// policy in register 0, among the entries counted by register 1. The
// configuration port writes a register at each edge with cfg_we high; the user
// must write it only while the block is idle, and the block does not enforce it.
// Operation: a load writes its entry and prepares its result on acceptance,
// and the result then moves into the output register. A request reads the
// table one entry per cycle through a single comparator, then commits the
// update and moves its result into the output register. A new word is taken
// only after the previous result has been pushed into the output register.
// Reset (rst_n low, synchronous) clears the pointer, the policy (first fit),
// the entry count (sixteen) and the output valid flag; table contents are not
// cleared and must be loaded before use. If out_ch stalls, the finished
// result waits in the output register and the next result waits inside.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
  fpba_in_if.sink                              in_ch,
  fpba_out_if.source                           out_ch
);

  fpba_pkg::fpba_cmd_t    cmd;
  fpba_pkg::fpba_status_t status;
  logic                   in_ready;
  logic                   out_valid;
  logic                   out_granted;
  logic [fpba_pkg::ENTRY_W-1:0]  out_chosen_block;
  logic [fpba_pkg::AMOUNT_W-1:0] out_space_left;

  fpba_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  fpba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_entry_index   (in_ch.entry_index),
    .in_amount        (in_ch.amount),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_space_left   (out_space_left)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.granted      = out_granted;
  assign out_ch.chosen_block = out_chosen_block;
  assign out_ch.space_left   = out_space_left;

endmodule : fit_policy_block_allocator

`default_nettype wire

FILE: sv/fpba_ctrl.sv
// ---------------------------------------------------------------------------
// fpba_ctrl: sequencing controller
// Accepts one word at a time, runs the table scan for requests, commits the
// update and hands the result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpba_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_operation,
  output logic                        in_ready,
  input  wire fpba_pkg::fpba_status_t status,
  output fpba_pkg::fpba_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_DELIVER
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == fpba_pkg::OP_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = S_DELIVER;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DELIVER;
      end
      S_DELIVER: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The scan state is left only once the datapath reports the scan complete.
  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !status.scan_done) |=> state_r == S_SCAN)
    else $error("scan state left before the scan finished");

  // A commit always follows a finished scan.
  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $past(status.scan_done))
    else $error("commit without a finished scan");

  // A new word is taken only after the previous result was handed over.
  a_accept_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && $past(state_r) == S_DELIVER) |-> $past(cmd.push))
    else $error("controller returned to idle without pushing a result");

endmodule : fpba_ctrl

`default_nettype wire

FILE: sv/fpba_dp.sv
// ---------------------------------------------------------------------------
// fpba_dp: allocator datapath
// Free size table memory, configuration registers, next-fit pointer, the
// single-comparator scan pipeline and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpba_dp #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [fpba_pkg::ENTRY_W-1:0]      in_entry_index,
  input  wire logic [fpba_pkg::AMOUNT_W-1:0]     in_amount,
  input  wire fpba_pkg::fpba_cmd_t               cmd,
  output fpba_pkg::fpba_status_t                 status,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic                                   out_granted,
  output logic [fpba_pkg::ENTRY_W-1:0]           out_chosen_block,
  output logic [fpba_pkg::AMOUNT_W-1:0]          out_space_left
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  // Configuration.
  fpba_pkg::fit_policy_t              policy_r;
  logic [fpba_pkg::CFG_DATA_W-1:0]    blocks_r;

  // Table memory and its read port.
  logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] mem_q_r;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  // Scan state.
  logic [IDX_W-1:0]     ptr_r;
  logic [SIZE_BITS-1:0] need_r;
  logic [IDX_W-1:0]     rd_addr_r;
  logic [CNT_W-1:0]     iss_left_r;
  logic                 rd_pend_r;
  logic [IDX_W-1:0]     cmp_addr_r;
  logic                 cand_found_r;
  logic [IDX_W-1:0]     cand_idx_r;
  logic [SIZE_BITS-1:0] cand_val_r;

  // Prepared result and output register.
  logic                              res_granted_r;
  logic [fpba_pkg::ENTRY_W-1:0]      res_idx_r;
  logic [fpba_pkg::AMOUNT_W-1:0]     res_left_r;
  logic                              out_valid_r;
  logic                              out_granted_r;
  logic [fpba_pkg::ENTRY_W-1:0]      out_idx_r;
  logic [fpba_pkg::AMOUNT_W-1:0]     out_left_r;

  logic [CNT_W-1:0]     n_active;
  logic [CNT_W-1:0]     rd_addr_inc;
  logic [IDX_W-1:0]     rd_addr_nxt;
  logic                 issue;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] load_size;
  logic [SIZE_BITS-1:0] left_after;
  logic                 fits;
  logic                 take;

  always_comb begin
    if (int'(blocks_r) > MAX_BLOCKS) begin
      n_active = CNT_W'(MAX_BLOCKS);
    end else begin
      n_active = CNT_W'(blocks_r);
    end
  end

  assign issue       = cmd.scan && (iss_left_r != '0);
  assign rd_addr_inc = CNT_W'(rd_addr_r) + CNT_W'(1);
  assign rd_addr_nxt = (rd_addr_inc >= n_active) ? '0 : IDX_W'(rd_addr_inc);

  assign load_ok    = int'(in_entry_index) < MAX_BLOCKS;
  assign load_size  = SIZE_BITS'(in_amount);
  assign left_after = cand_val_r - need_r;

  // Strict compares keep ties on the earliest entry seen in scan order.
  assign fits = mem_q_r >= need_r;
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!cand_found_r) begin
        take = 1'b1;
      end else begin
        priority case (policy_r)
          fpba_pkg::FIT_BEST:  take = mem_q_r < cand_val_r;
          fpba_pkg::FIT_WORST: take = mem_q_r > cand_val_r;
          default:             take = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cand_idx_r;
    wr_data = left_after;
    if (cmd.load) begin
      wr_en   = load_ok;
      wr_addr = IDX_W'(in_entry_index);
      wr_data = load_size;
    end else if (cmd.commit) begin
      wr_en = cand_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      mem_q_r <= mem[rd_addr_r];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpba_pkg::FIT_FIRST;
      blocks_r <= fpba_pkg::BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpba_pkg::CFG_FIT_POLICY:    policy_r <= fpba_pkg::fit_policy_t'(cfg_data[1:0]);
        fpba_pkg::CFG_BLOCKS_IN_USE: blocks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state of the scan and the pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      iss_left_r   <= '0;
      rd_pend_r    <= 1'b0;
      cand_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pend_r <= issue;
      if (cmd.load && load_ok) begin
        ptr_r <= '0;
      end
      if (cmd.capture) begin
        iss_left_r   <= n_active;
        cand_found_r <= 1'b0;
      end else if (issue) begin
        iss_left_r <= iss_left_r - CNT_W'(1);
      end
      if (rd_pend_r && take) begin
        cand_found_r <= 1'b1;
      end
      if (cmd.commit && cand_found_r && policy_r == fpba_pkg::FIT_NEXT) begin
        ptr_r <= cand_idx_r;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      need_r <= load_size;
      // A stale pointer restarts the next-fit scan at entry zero.
      if (policy_r == fpba_pkg::FIT_NEXT && CNT_W'(ptr_r) < n_active) begin
        rd_addr_r <= ptr_r;
      end else begin
        rd_addr_r <= '0;
      end
    end else if (issue) begin
      rd_addr_r <= rd_addr_nxt;
    end
    if (issue) begin
      cmp_addr_r <= rd_addr_r;
    end
    if (rd_pend_r && take) begin
      cand_idx_r <= cmp_addr_r;
      cand_val_r <= mem_q_r;
    end
    if (cmd.load) begin
      res_granted_r <= load_ok;
      res_idx_r     <= load_ok ? in_entry_index : '0;
      res_left_r    <= load_ok ? fpba_pkg::AMOUNT_W'(load_size) : '0;
    end else if (cmd.commit) begin
      res_granted_r <= cand_found_r;
      res_idx_r     <= cand_found_r ? fpba_pkg::ENTRY_W'(cand_idx_r) : '0;
      res_left_r    <= cand_found_r ? fpba_pkg::AMOUNT_W'(left_after) : '0;
    end
    if (cmd.push) begin
      out_granted_r <= res_granted_r;
      out_idx_r     <= res_idx_r;
      out_left_r    <= res_left_r;
    end
  end

  assign status.scan_done = (iss_left_r == '0) && !rd_pend_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_idx_r;
  assign out_space_left   = out_left_r;

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result pushed over a word not yet taken");

  // The output register only fills through a push.
  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(cmd.push))
    else $error("output valid without a push");

  // The table is updated only after every read of the scan has been compared.
  a_commit_idle_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (iss_left_r == '0 && !rd_pend_r))
    else $error("commit while the scan is still running");

endmodule : fpba_dp

`default_nettype wire

FILE: tb/fit_policy_block_allocator_test.sv
// ---------------------------------------------------------------------------
// fit_policy_block_allocator_test: self-checking bench for the block allocator
// Loads the free size table, then places requests under all four fit policies
// and a range of entry counts. Each accepted input word is run through a
// behavioral copy of the allocator, and every result word is compared field
// by field with the oldest prediction. Both channels stall in random bursts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fit_policy_block_allocator_test;
  import fpba_pkg::*;

  localparam int BLOCKS       = MAX_BLOCKS_DEF;
  localparam int RANDOM_WORDS = 850;
  localparam int CALM_WORDS   = 150;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic                granted;
    logic [ENTRY_W-1:0]  block;
    logic [AMOUNT_W-1:0] left;
  } grant_t;

  class alloc_checker;
    logic [AMOUNT_W-1:0]   free_size [BLOCKS];
    logic [ENTRY_W-1:0]    next_ptr;
    fit_policy_t           policy;
    logic [CFG_DATA_W-1:0] blocks_used;
    grant_t                expected_grants [$];
    int                    mismatches;

    function new();
      foreach (free_size[i]) free_size[i] = '0;
      next_ptr    = '0;
      policy      = FIT_FIRST;
      blocks_used = BLOCKS_IN_USE_RST;
      mismatches  = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FIT_POLICY) begin
        policy = fit_policy_t'(data[1:0]);
      end else if (idx == CFG_BLOCKS_IN_USE) begin
        blocks_used = data;
      end
    endfunction

    // Returns the entry that the current policy places a request in, or -1.
    function int pick_block(logic [AMOUNT_W-1:0] need);
      int n;
      int pos;
      int pick;
      int i;
      n    = (blocks_used > BLOCKS) ? BLOCKS : int'(blocks_used);
      pick = -1;
      if (policy == FIT_NEXT) begin
        // A pointer left beyond the active entries restarts the scan at 0.
        pos = (int'(next_ptr) < n) ? int'(next_ptr) : 0;
        for (i = 0; i < n; i++) begin
          if (free_size[pos] >= need) return pos;
          pos = (pos + 1 >= n) ? 0 : pos + 1;
        end
        return -1;
      end
      for (i = 0; i < n; i++) begin
        if (free_size[i] >= need) begin
          if (policy == FIT_FIRST) return i;
          if (pick < 0 ||
              (policy == FIT_BEST && free_size[i] < free_size[pick]) ||
              (policy == FIT_WORST && free_size[i] > free_size[pick]))
            pick = i;
        end
      end
      return pick;
    endfunction

    function void note_word(logic op, logic [ENTRY_W-1:0] idx, logic [AMOUNT_W-1:0] amount);
      grant_t g;
      int     pick;
      g = '0;
      if (op == OP_LOAD) begin
        free_size[idx] = amount;
        next_ptr       = '0;
        g.granted      = 1'b1;
        g.block        = idx;
        g.left         = amount;
      end else begin
        pick = pick_block(amount);
        if (pick >= 0) begin
          free_size[pick] = free_size[pick] - amount;
          if (policy == FIT_NEXT) next_ptr = ENTRY_W'(pick);
          g.granted = 1'b1;
          g.block   = ENTRY_W'(pick);
          g.left    = free_size[pick];
        end
      end
      expected_grants.push_back(g);
    endfunction

    function void check_grant(logic granted, logic [ENTRY_W-1:0] block,
                              logic [AMOUNT_W-1:0] left);
      grant_t want;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: granted %0d block %0d left %0h",
                   granted, block, left);
        return;
      end
      want = expected_grants.pop_front();
      if (granted !== want.granted || block !== want.block || left !== want.left) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected granted %0d block %0d left %0h, got %0d %0d %0h",
                   want.granted, want.block, want.left, granted, block, left);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIT_POLICY;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  bit                    bursty    = 1'b1;
  int                    cycle_count;
  alloc_checker          alloc_sb  = new();

  fpba_in_if  in_ch ();
  fpba_out_if out_ch ();

  fit_policy_block_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial forever #6 clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: ready drops in random bursts while bursty is set.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (bursty && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      alloc_sb.check_grant(out_ch.granted, out_ch.chosen_block, out_ch.space_left);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic op, input logic [ENTRY_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amount);
    if (bursty && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx;
    in_ch.amount      <= amount;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    alloc_sb.note_word(op, idx, amount);
    @(negedge clk);
  endtask

  // The loop always advances to a falling edge first, so valid is never lowered and raised at once.
  task automatic drain_block(input int settle);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (alloc_sb.expected_grants.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_config(input fit_policy_t pol, input logic [CFG_DATA_W-1:0] blocks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIT_POLICY;
    cfg_data  <= CFG_DATA_W'(pol);
    alloc_sb.set_register(CFG_FIT_POLICY, CFG_DATA_W'(pol));
    @(negedge clk);
    cfg_index <= CFG_BLOCKS_IN_USE;
    cfg_data  <= blocks;
    alloc_sb.set_register(CFG_BLOCKS_IN_USE, blocks);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [AMOUNT_W-1:0] load_size();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2, 3:    return AMOUNT_W'($urandom);
      4:       return AMOUNT_W'(500);  // a shared size makes best and worst fit ties
      default: return AMOUNT_W'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [AMOUNT_W-1:0] request_size();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return AMOUNT_W'($urandom);
      3:       return AMOUNT_W'($urandom_range(0, 4000));
      default: return AMOUNT_W'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(BLOCKS);
      3:       return CFG_DATA_W'($urandom_range(BLOCKS + 1, 31));
      default: return CFG_DATA_W'($urandom_range(1, BLOCKS));
    endcase
  endfunction

  initial begin
    logic [AMOUNT_W-1:0] seed_sizes [BLOCKS];
    int                  done;
    int                  phase_len;
    int                  i;
    seed_sizes = '{16'hFFFF, 16'd100, 16'h8000, 16'd1, 16'd200, 16'd237, 16'd274, 16'd311,
                   16'd500, 16'd500, 16'd385, 16'd422, 16'd459, 16'd1300, 16'd500, 16'd0};
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_LOAD;
    in_ch.entry_index = '0;
    in_ch.amount      = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every entry is loaded before the first request, so no scan reads an
    // entry that was never written.
    write_config(FIT_FIRST, CFG_DATA_W'(BLOCKS));
    for (i = 0; i < BLOCKS; i++) send_word(OP_LOAD, ENTRY_W'(i), seed_sizes[i]);
    send_word(OP_REQUEST, 4'hF, 16'h0000);
    send_word(OP_REQUEST, 4'h0, 16'hFFFF);
    send_word(OP_REQUEST, 4'hA, 16'hFFFF);
    send_word(OP_REQUEST, 4'h5, 16'h8000);

    // Next fit lands on entry 13, then the entry count shrinks below the
    // pointer so the following scan has to restart at entry 0.
    drain_block(4);
    write_config(FIT_NEXT, CFG_DATA_W'(BLOCKS));
    send_word(OP_LOAD, 4'd13, 16'hA000);
    send_word(OP_REQUEST, 4'd0, 16'h9000);
    drain_block(4);
    write_config(FIT_NEXT, CFG_DATA_W'(4));
    send_word(OP_REQUEST, 4'd0, 16'd1);

    // With no entries in use even a zero-size request is refused.
    drain_block(4);
    write_config(FIT_BEST, '0);
    send_word(OP_REQUEST, 4'd0, 16'd0);
    drain_block(4);
    write_config(FIT_WORST, '1);
    send_word(OP_REQUEST, 4'd3, 16'd10);
    drain_block(4);
    write_config(FIT_BEST, CFG_DATA_W'(BLOCKS));
    send_word(OP_REQUEST, 4'd7, 16'd500);

    done = 0;
    while (done < RANDOM_WORDS) begin
      drain_block(4);
      write_config(fit_policy_t'($urandom_range(0, 3)), random_count());
      if (done < RANDOM_WORDS - CALM_WORDS) bursty = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 60);
      for (i = 0; i < phase_len && done < RANDOM_WORDS; i++) begin
        if (done == RANDOM_WORDS - CALM_WORDS) bursty = 1'b0;
        if ($urandom_range(0, 3) == 0)
          send_word(OP_LOAD, ENTRY_W'($urandom_range(0, 15)), load_size());
        else
          send_word(OP_REQUEST, ENTRY_W'($urandom_range(0, 15)), request_size());
        done++;
        // Now and then the sender holds off until the block has emptied.
        if (bursty && $urandom_range(0, 49) == 0) drain_block(0);
      end
    end

    drain_block(30);
    if (alloc_sb.mismatches == 0 && alloc_sb.expected_grants.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
sv/fpba_pkg.sv
sv/fpba_if.sv
sv/fpba_ctrl.sv
sv/fpba_dp.sv
sv/fit_policy_block_allocator.sv
tb/fit_policy_block_allocator_test.sv
